// ----- rtl/core/ufs_pkg.sv -----
// Package for the union-find component-sum block.
// Holds the sizes, the word structs and the control struct of the sorted cell chain.
package ufs_pkg;

  localparam int NODES = 1024;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  typedef struct packed {
    logic [IDX_W-1:0] node_a;
    logic [IDX_W-1:0] node_b;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] answer;
    logic             redundant_edge;
    logic [CNT_W-1:0] component_count;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic ins;
    logic shift;
  } chain_ctl_t;

endpackage

// ----- rtl/core/union_find_top_component_sum.sv -----
// Steps per word: accept it, walk to each root and compress the path on both sides if both nodes
// are in range, merge the sizes of two distinct roots, scan the roots into the sorted chain, sum
// the chain heads (at most redundant count + 1) and hand off the word; a new word is accepted
// only after the last one is handed off, since in_ready is high only in the idle state.
// Reset: synchronous; afterwards a clearing pass sets the stores before the first word.
module union_find_top_component_sum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ufs_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ufs_pkg::out_word_t        out_data,
  input  logic                      cfg_we,
  input  logic [ufs_pkg::CNT_W-1:0] cfg_wdata
);
  import ufs_pkg::*;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WALK1 = 4'd2;
  localparam logic [3:0] ST_WALK2 = 4'd3;
  localparam logic [3:0] ST_COMP1 = 4'd4;
  localparam logic [3:0] ST_COMP2 = 4'd5;
  localparam logic [3:0] ST_SZB1  = 4'd6;
  localparam logic [3:0] ST_SZB2  = 4'd7;
  localparam logic [3:0] ST_SZA1  = 4'd8;
  localparam logic [3:0] ST_SZA2  = 4'd9;
  localparam logic [3:0] ST_SCAN  = 4'd10;
  localparam logic [3:0] ST_DRAIN = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [IDX_W-1:0] parent_mem [NODES];
  logic [CNT_W-1:0] size_mem   [NODES];

  logic [3:0]       state_r;
  logic [CNT_W-1:0] node_count_r;
  logic [IDX_W-1:0] clr_r;
  logic [IDX_W-1:0] cur_r, start_r, root_r, ra_r, b_r;
  logic             side_r, red_r;
  logic [CNT_W-1:0] n_r, i_r, comps_r, rc_r, cnt_r, sum_r, szb_r;
  logic             sv_r;
  logic [IDX_W-1:0] sidx_r;
  out_word_t        res_r, out_r;
  logic             out_valid_r;

  logic [IDX_W-1:0] p_raddr, p_waddr, p_wdata, p_rd, s_raddr, s_waddr;
  logic [CNT_W-1:0] s_wdata, s_rd, n_live, want, head;
  logic             p_we, s_we, issue;
  chain_ctl_t       ctl;

  always_comb begin
    n_live = node_count_r;
    if (node_count_r == '0) begin
      n_live = CNT_W'(1);
    end else if (node_count_r > CNT_W'(NODES)) begin
      n_live = CNT_W'(NODES);
    end
  end

  assign want  = rc_r + CNT_W'(1);
  assign issue = i_r < n_r;

  always_comb begin
    p_raddr = cur_r;
    s_raddr = root_r;
    if (state_r == ST_SCAN) begin
      p_raddr = i_r[IDX_W-1:0];
      s_raddr = i_r[IDX_W-1:0];
    end else if (state_r == ST_SZA1) begin
      s_raddr = ra_r;
    end
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_r;
    s_we    = 1'b0;
    s_waddr = ra_r;
    s_wdata = s_rd + szb_r;
    if (state_r == ST_CLR) begin
      p_we    = 1'b1;
      p_waddr = clr_r;
      p_wdata = clr_r;
      s_we    = 1'b1;
      s_waddr = clr_r;
      s_wdata = CNT_W'(1);
    end else if (state_r == ST_COMP2 && cur_r != root_r) begin
      p_we = 1'b1;
    end else if (state_r == ST_SZA2) begin
      p_we    = 1'b1;
      p_waddr = root_r;
      p_wdata = ra_r;
      s_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    p_rd <= parent_mem[p_raddr];
    s_rd <= size_mem[s_raddr];
  end

  always_comb begin
    ctl.clear = (state_r != ST_SCAN) && (state_r != ST_DRAIN);
    ctl.ins   = (state_r == ST_SCAN) && sv_r && (p_rd == sidx_r);
    ctl.shift = (state_r == ST_DRAIN) && (comps_r > rc_r) && (cnt_r < want) &&
                (head != '0);
  end

  ufs_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .x    (s_rd),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      node_count_r <= CNT_W'(NODES);
      clr_r        <= '0;
      rc_r         <= '0;
      out_valid_r  <= 1'b0;
      sv_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == IDX_W'(NODES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          i_r     <= '0;
          sv_r    <= 1'b0;
          comps_r <= '0;
          red_r   <= 1'b0;
          if (in_valid) begin
            n_r     <= n_live;
            cur_r   <= in_data.node_a;
            start_r <= in_data.node_a;
            b_r     <= in_data.node_b;
            side_r  <= 1'b0;
            if ({1'b0, in_data.node_a} < n_live && {1'b0, in_data.node_b} < n_live) begin
              state_r <= ST_WALK1;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_WALK1: state_r <= ST_WALK2;
        ST_WALK2: begin
          if (p_rd == cur_r) begin
            root_r  <= cur_r;
            cur_r   <= start_r;
            state_r <= ST_COMP1;
          end else begin
            cur_r   <= p_rd;
            state_r <= ST_WALK1;
          end
        end
        ST_COMP1: state_r <= ST_COMP2;
        ST_COMP2: begin
          if (cur_r != root_r) begin
            cur_r   <= p_rd;
            state_r <= ST_COMP1;
          end else if (!side_r) begin
            ra_r    <= root_r;
            cur_r   <= b_r;
            start_r <= b_r;
            side_r  <= 1'b1;
            state_r <= ST_WALK1;
          end else if (ra_r == root_r) begin
            red_r <= 1'b1;
            if (rc_r < CNT_W'(NODES)) begin
              rc_r <= rc_r + CNT_W'(1);
            end
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_SZB1;
          end
        end
        ST_SZB1: state_r <= ST_SZB2;
        ST_SZB2: begin
          szb_r   <= s_rd;
          state_r <= ST_SZA1;
        end
        ST_SZA1: state_r <= ST_SZA2;
        ST_SZA2: state_r <= ST_SCAN;
        ST_SCAN: begin
          sv_r   <= issue;
          sidx_r <= i_r[IDX_W-1:0];
          if (issue) begin
            i_r <= i_r + CNT_W'(1);
          end
          if (ctl.ins) begin
            comps_r <= comps_r + CNT_W'(1);
          end
          if (!issue && !sv_r) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (ctl.shift) begin
            sum_r <= sum_r + head;
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            res_r.redundant_edge  <= red_r;
            res_r.component_count <= comps_r;
            if (comps_r <= rc_r || (sum_r - CNT_W'(1)) > (n_r - CNT_W'(1))) begin
              res_r.answer <= IDX_W'(n_r - CNT_W'(1));
            end else begin
              res_r.answer <= IDX_W'(sum_r - CNT_W'(1));
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/ufs_cell.sv -----
// One cell of the descending sorted chain of component sizes.
// Depends on ufs_pkg for widths and the control struct.
module ufs_cell (
  input  logic                     clk,
  input  ufs_pkg::chain_ctl_t      ctl,
  input  logic [ufs_pkg::CNT_W-1:0] x,
  input  logic [ufs_pkg::CNT_W-1:0] prev_v,
  input  logic                     prev_gt,
  input  logic [ufs_pkg::CNT_W-1:0] next_v,
  output logic [ufs_pkg::CNT_W-1:0] v,
  output logic                     gt
);
  import ufs_pkg::*;

  logic [CNT_W-1:0] v_r;

  assign v  = v_r;
  assign gt = x > v_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      v_r <= '0;
    end else if (ctl.shift) begin
      v_r <= next_v;
    end else if (ctl.ins && gt) begin
      v_r <= prev_gt ? prev_v : x;
    end
  end

endmodule

// ----- rtl/core/ufs_chain.sv -----
// Row of sorted cells that keeps the root sizes in descending order.
// Depends on ufs_pkg and ufs_cell; the head cell holds the largest size.
module ufs_chain (
  input  logic                      clk,
  input  ufs_pkg::chain_ctl_t       ctl,
  input  logic [ufs_pkg::CNT_W-1:0] x,
  output logic [ufs_pkg::CNT_W-1:0] head
);
  import ufs_pkg::*;

  logic [CNT_W-1:0] v_w  [NODES];
  logic             gt_w [NODES];

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    logic [CNT_W-1:0] pv;
    logic             pg;
    logic [CNT_W-1:0] nv;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = v_w[i-1];
      assign pg = gt_w[i-1];
    end
    if (i == NODES - 1) begin : g_last
      assign nv = '0;
    end else begin : g_inner
      assign nv = v_w[i+1];
    end
    ufs_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .x       (x),
      .prev_v  (pv),
      .prev_gt (pg),
      .next_v  (nv),
      .v       (v_w[i]),
      .gt      (gt_w[i])
    );
  end

  assign head = v_w[0];

endmodule

// ----- sim/union_find_top_component_sum_tb.sv -----
// Testbench for the union-find component-sum block: random and directed edges over
// several node counts, checked word by word against a scoreboard holding its own forest.
// Depends on ufs_pkg and union_find_top_component_sum.
`timescale 1ns / 1ps

module union_find_top_component_sum_tb;
  import ufs_pkg::*;

  class dsu_scoreboard;
    logic [IDX_W-1:0] parent[NODES];
    logic [CNT_W-1:0] comp_size[NODES];
    int unsigned redundant_total;
    logic [CNT_W-1:0] node_reg;
    out_word_t expected_words[$];
    int errors;

    function new();
      for (int i = 0; i < NODES; i++) begin
        parent[i] = IDX_W'(i);
        comp_size[i] = CNT_W'(1);
      end
      redundant_total = 0;
      node_reg = CNT_W'(NODES);
      errors = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      node_reg = v;
    endfunction

    function int unsigned live_count();
      if (node_reg < 1) return 1;
      if (node_reg > NODES) return NODES;
      return 32'(node_reg);
    endfunction

    function int unsigned root_of(int unsigned x);
      int unsigned r;
      int unsigned nxt;
      r = x;
      while (parent[r] != r) r = parent[r];
      while (x != r) begin
        nxt = parent[x];
        parent[x] = IDX_W'(r);
        x = nxt;
      end
      return r;
    endfunction

    function void note_edge(in_word_t w);
      int unsigned n;
      int unsigned ra;
      int unsigned rb;
      int unsigned comps;
      int unsigned want;
      int unsigned take;
      int unsigned sum;
      int unsigned ans;
      int unsigned hist[NODES+1];
      out_word_t o;
      n = live_count();
      o.redundant_edge = 1'b0;
      if (w.node_a < n && w.node_b < n) begin
        ra = root_of(32'(w.node_a));
        rb = root_of(32'(w.node_b));
        if (ra == rb) begin
          o.redundant_edge = 1'b1;
          if (redundant_total < NODES) redundant_total++;
        end else begin
          comp_size[ra] = comp_size[ra] + comp_size[rb];
          parent[rb] = IDX_W'(ra);
        end
      end
      for (int s = 0; s <= NODES; s++) hist[s] = 0;
      comps = 0;
      for (int i = 0; i < n; i++) begin
        if (parent[i] == i) begin
          hist[(comp_size[i] > NODES) ? NODES : comp_size[i]]++;
          comps++;
        end
      end
      if (comps <= redundant_total) begin
        ans = n - 1;
      end else begin
        want = redundant_total + 1;
        sum = 0;
        for (int s = NODES; s > 0 && want > 0; s--) begin
          take = (hist[s] > want) ? want : hist[s];
          sum += take * s;
          want -= take;
        end
        ans = (sum > 0) ? sum - 1 : 0;
        if (ans > n - 1) ans = n - 1;
      end
      o.answer = IDX_W'(ans);
      o.component_count = CNT_W'(comps);
      expected_words.push_back(o);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.answer !== exp_w.answer) begin
        $display("%0t: answer expected %0d actual %0d", $time, exp_w.answer, got.answer);
        errors++;
      end
      if (got.redundant_edge !== exp_w.redundant_edge) begin
        $display("%0t: redundant_edge expected %0d actual %0d", $time,
                 exp_w.redundant_edge, got.redundant_edge);
        errors++;
      end
      if (got.component_count !== exp_w.component_count) begin
        $display("%0t: component_count expected %0d actual %0d", $time,
                 exp_w.component_count, got.component_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  dsu_scoreboard board;
  bit long_hold;
  bit no_idle;
  int unsigned cycle_count;

  union_find_top_component_sum DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    long_hold = 1'b0;
    no_idle = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 30000000) begin
      $display("union_find_top_component_sum_tb: errors");
      $finish;
    end
  end

  task automatic send_edge(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    int unsigned gap;
    bit rdy;
    in_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    w.node_a = a;
    w.node_b = b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    board.note_edge(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(v);
  endtask

  task automatic random_phase(input logic [CNT_W-1:0] v, input int items);
    int unsigned n;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    write_count(v);
    n = board.live_count();
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        a = IDX_W'($urandom);
        b = IDX_W'($urandom);
      end else begin
        a = IDX_W'($urandom_range(0, n - 1));
        b = IDX_W'($urandom_range(0, n - 1));
      end
      send_edge(a, b);
    end
    wait_idle();
  endtask

  initial begin : receiver
    int unsigned hold;
    bit vld;
    out_word_t got;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        hold = 600;
        long_hold = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        vld = out_valid;
        got = out_data;
        @(posedge clk);
      end while (!vld);
      board.check_word(got);
    end
  end

  initial begin : stimulus
    board = new();
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edge(0, 0);
    send_edge(1023, 1023);
    send_edge(0, 1023);
    send_edge(1023, 0);
    send_edge(10'h2AA, 10'h155);
    send_edge(10'h155, 10'h2AA);
    send_edge(1, 2);
    send_edge(2, 1023);
    wait_idle();
    write_count(5);
    send_edge(7, 1);
    send_edge(1, 7);
    send_edge(4, 3);
    send_edge(3, 4);
    send_edge(1023, 4);
    wait_idle();

    random_phase(1024, 20);
    random_phase(1, 10);
    random_phase(2, 15);
    no_idle = 1'b1;
    random_phase(37, 40);
    no_idle = 1'b0;
    long_hold = 1'b1;
    random_phase(16, 45);
    random_phase(0, 10);
    random_phase(5, 20);
    random_phase(200, 50);
    random_phase(2047, 15);
    random_phase(64, 40);

    wait_idle();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("union_find_top_component_sum_tb: clean");
    end else begin
      $display("union_find_top_component_sum_tb: errors");
    end
    $finish;
  end

endmodule
